// ----- sv/swtq_pkg.sv -----
// ----------------------------------------------------------------------------
// swtq_pkg
// shared types and constants for the sleep/wake timer queue
// ----------------------------------------------------------------------------
package swtq_pkg;

    localparam int TICK_W = 64;
    localparam int MAX_BURST = 16;

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_IGNORED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_WOKEN    = 3'd3,
        ST_NONE_DUE = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_REMOVE,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture input item, clear scan state
        logic tick;     // advance tick counter
        logic step;     // examine one slot
        logic insert;   // write new entry into free slot
        logic remove;   // release the best entry
        logic emit;     // drive one result
        logic emit_last;
        t_status emit_status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
        logic bad_count;
        logic scan_end;
        logic have_free;
        logic have_best;
    } t_stat;

endpackage

// ----- sv/sleep_wake_timer_queue.sv -----
// ----------------------------------------------------------------------------
// sleep_wake_timer_queue
// hardware alarm-clock queue of sleeping threads with priority wake-up
// ----------------------------------------------------------------------------
// an item is taken when start is high and busy low. every item gives its
// results on o_valid, one cycle each, which the receiver cannot stall. a
// sleep request walks all QUEUE_DEPTH slots one per cycle (count of used
// slots, first free slot) and keeps busy high through the walk and the
// decision after it; its result then passes the result register and the
// output stage, and the next item is taken only once busy falls. a tick
// advances the counter and then repeats that walk once per released entry,
// picking the best due entry (highest priority, then earliest wake time,
// then latest request), at most 16 releases per tick. a woken result is held
// back in the output stage until the next release or the end of the burst.
// the burst closes with one more walk that finds nothing due plus a done
// step that flags the final result, or with just that done step after the
// sixteenth release. the walk over the slot registers, one comparator shared
// by all slots, sets the rate.
module sleep_wake_timer_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_action,
    input  logic [7:0]         i_thread_id,
    input  logic signed [31:0] i_sleep_ticks,
    input  logic [5:0]         i_priority_req,
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic [7:0]         o_woken_thread,
    output logic [5:0]         o_woken_priority,
    output logic               o_last,
    output logic [62:0]        o_tick_now
);
    import swtq_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic        w_v, w_l;
    logic [2:0]  w_s;
    logic [7:0]  w_t;
    logic [5:0]  w_p;
    logic [62:0] w_k;

    swtq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    swtq_dp #(.DEPTH(QUEUE_DEPTH)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_action         (i_action),
        .i_thread_id      (i_thread_id),
        .i_sleep_ticks    (i_sleep_ticks),
        .i_priority_req   (i_priority_req),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_valid          (w_v),
        .o_status         (w_s),
        .o_woken_thread   (w_t),
        .o_woken_priority (w_p),
        .o_last           (w_l),
        .o_tick_now       (w_k)
    );

    // holds each woken result back one step so the final one carries last
    swtq_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_v),
        .i_status   (w_s),
        .i_thread   (w_t),
        .i_priority (w_p),
        .i_last     (w_l),
        .i_tick     (w_k),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_thread   (o_woken_thread),
        .o_priority (o_woken_priority),
        .o_last     (o_last),
        .o_tick     (o_tick_now)
    );

endmodule

// ----- sv/swtq_ctrl.sv -----
// ----------------------------------------------------------------------------
// swtq_ctrl
// sequencer: scan slots, then insert or release entries one at a time
// ----------------------------------------------------------------------------
module swtq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  swtq_pkg::t_stat  i_stat,
    output swtq_pkg::t_cmd   o_cmd
);
    import swtq_pkg::*;

    t_state r_state, n_state;
    logic [4:0] r_burst, n_burst;
    logic r_any, n_any;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_burst <= '0;
            r_any   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_burst <= n_burst;
            r_any   <= n_any;
        end
    end

    always_comb begin
        n_state = r_state;
        n_burst = r_burst;
        n_any   = r_any;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SCAN;
                    n_burst = '0;
                    n_any   = 1'b0;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_end) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (!i_stat.is_tick) n_state = S_IDLE;
                else if (i_stat.have_best) n_state = S_REMOVE;
                else n_state = S_DONE;
            end
            S_REMOVE: begin
                n_burst = r_burst + 5'd1;
                n_any   = 1'b1;
                n_state = (r_burst == 5'(MAX_BURST - 1)) ? S_DONE : S_SCAN;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_busy = (r_state != S_IDLE);
        o_cmd = '0;
        o_cmd.emit_status = ST_ACCEPTED;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
                o_cmd.tick = i_start;
            end
            S_SCAN: o_cmd.step = 1'b1;
            S_DECIDE: begin
                if (!i_stat.is_tick) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    if (i_stat.bad_count) o_cmd.emit_status = ST_IGNORED;
                    else if (!i_stat.have_free) o_cmd.emit_status = ST_FULL;
                    else begin
                        o_cmd.emit_status = ST_ACCEPTED;
                        o_cmd.insert = 1'b1;
                    end
                end
            end
            S_REMOVE: begin
                o_cmd.remove = 1'b1;
                o_cmd.emit = 1'b1;
                o_cmd.emit_status = ST_WOKEN;
            end
            S_DONE: begin
                // close the burst: flush the held woken result or report nothing due
                o_cmd.emit = 1'b1;
                o_cmd.emit_last = 1'b1;
                o_cmd.emit_status = r_any ? ST_WOKEN : ST_NONE_DUE;
            end
            default: ;
        endcase
    end

endmodule

// ----- sv/swtq_dp.sv -----
// ----------------------------------------------------------------------------
// swtq_dp
// slot storage, tick counter and one-slot-a-cycle comparison datapath
// ----------------------------------------------------------------------------
module swtq_dp #(
    parameter int DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_action,
    input  logic [7:0]                    i_thread_id,
    input  logic signed [31:0]            i_sleep_ticks,
    input  logic [5:0]                    i_priority_req,
    input  swtq_pkg::t_cmd                i_cmd,
    output swtq_pkg::t_stat               o_stat,
    output logic                          o_valid,
    output logic [2:0]                    o_status,
    output logic [7:0]                    o_woken_thread,
    output logic [5:0]                    o_woken_priority,
    output logic                          o_last,
    output logic [62:0]                   o_tick_now
);
    import swtq_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [TICK_W-1:0] r_tick;
    logic [DEPTH-1:0]  r_valid;
    logic [7:0]        r_thr [DEPTH];
    logic [TICK_W-1:0] r_wake [DEPTH];
    logic [5:0]        r_pri [DEPTH];
    logic [CW-1:0]     r_ord [DEPTH];

    logic              r_act;
    logic [7:0]        r_in_thr;
    logic [31:0]       r_in_cnt;
    logic [5:0]        r_in_pri;

    logic [CW-1:0]     r_idx;      // scan position
    logic [CW-1:0]     r_used;
    logic              r_have_free;
    logic [IW-1:0]     r_free;
    logic              r_have_best;
    logic [IW-1:0]     r_best;
    logic [5:0]        r_bpri;
    logic [TICK_W-1:0] r_bwake;
    logic [CW-1:0]     r_bord;
    logic [7:0]        r_bthr;

    logic [IW-1:0]     w_i;
    logic              w_due, w_better;
    logic [TICK_W:0]   w_sum;
    logic [TICK_W-1:0] w_new_wake;

    assign w_i = r_idx[IW-1:0];
    assign w_due = r_valid[w_i] && (r_wake[w_i] <= r_tick);
    always_comb begin
        if (r_pri[w_i] != r_bpri) w_better = r_pri[w_i] > r_bpri;
        else if (r_wake[w_i] != r_bwake) w_better = r_wake[w_i] < r_bwake;
        else w_better = r_ord[w_i] > r_bord;
    end

    assign w_sum = {1'b0, r_tick} + {{(TICK_W - 31){1'b0}}, r_in_cnt};
    assign w_new_wake = w_sum[TICK_W] ? '1 : w_sum[TICK_W-1:0];

    assign o_stat.is_tick   = r_act;
    assign o_stat.bad_count = (r_in_cnt == '0) || r_in_cnt[31];
    assign o_stat.scan_end  = (r_idx == CW'(DEPTH - 1));
    assign o_stat.have_free = r_have_free;
    assign o_stat.have_best = r_have_best;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_valid <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
            if (i_cmd.tick && i_action) r_tick <= r_tick + 1'b1;
            if (i_cmd.insert) r_valid[r_free] <= 1'b1;
            if (i_cmd.remove) r_valid[r_best] <= 1'b0;
        end
    end

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act    <= i_action;
            r_in_thr <= i_thread_id;
            r_in_cnt <= i_sleep_ticks;
            r_in_pri <= i_priority_req;
        end
        if (i_cmd.load || i_cmd.remove) begin
            r_idx <= '0;
            r_used <= '0;
            r_have_free <= 1'b0;
            r_free <= '0;
            r_have_best <= 1'b0;
            r_best <= '0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + 1'b1;
            if (r_valid[w_i]) r_used <= r_used + 1'b1;
            else if (!r_have_free) begin
                r_have_free <= 1'b1;
                r_free <= w_i;
            end
            if (w_due && (!r_have_best || w_better)) begin
                r_have_best <= 1'b1;
                r_best  <= w_i;
                r_bpri  <= r_pri[w_i];
                r_bwake <= r_wake[w_i];
                r_bord  <= r_ord[w_i];
                r_bthr  <= r_thr[w_i];
            end
        end
        if (i_cmd.insert) begin
            r_thr[r_free]  <= r_in_thr;
            r_wake[r_free] <= w_new_wake;
            r_pri[r_free]  <= r_in_pri;
            r_ord[r_free]  <= r_used;
        end
        if (i_cmd.remove) begin
            for (int k = 0; k < DEPTH; k++)
                if (r_valid[k] && r_ord[k] > r_bord) r_ord[k] <= r_ord[k] - 1'b1;
        end
    end

    // result register; the output stage decides which woken result is last
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_status   <= i_cmd.emit_status;
            o_last     <= i_cmd.emit_last;
            o_tick_now <= r_tick[62:0];
            if (i_cmd.remove) begin
                o_woken_thread   <= r_bthr;
                o_woken_priority <= r_bpri;
            end else if (i_cmd.emit_status == ST_NONE_DUE) begin
                o_woken_thread   <= '0;
                o_woken_priority <= '0;
            end else begin
                o_woken_thread   <= r_in_thr;
                o_woken_priority <= r_in_pri;
            end
        end
    end

endmodule

// ----- sv/swtq_out.sv -----
// ----------------------------------------------------------------------------
// swtq_out
// one-deep hold stage so that the last woken result can be flagged
// ----------------------------------------------------------------------------
module swtq_out (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [2:0]  i_status,
    input  logic [7:0]  i_thread,
    input  logic [5:0]  i_priority,
    input  logic        i_last,
    input  logic [62:0] i_tick,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [7:0]  o_thread,
    output logic [5:0]  o_priority,
    output logic        o_last,
    output logic [62:0] o_tick
);
    import swtq_pkg::*;

    logic        r_hv;
    logic [2:0]  r_st;
    logic [7:0]  r_th;
    logic [5:0]  r_pr;
    logic [62:0] r_tk;

    // a woken result without last is a release, with last it is the closing marker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_valid) begin
                if (i_status == ST_WOKEN && !i_last) begin
                    // new release: flush the previous one as not last
                    o_valid <= r_hv;
                    r_hv    <= 1'b1;
                end else begin
                    o_valid <= 1'b1;
                    r_hv    <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            if (i_status == ST_WOKEN) begin
                o_status   <= r_st;
                o_thread   <= r_th;
                o_priority <= r_pr;
                o_last     <= i_last;
                o_tick     <= r_tk;
                if (!i_last) begin
                    r_st <= i_status;
                    r_th <= i_thread;
                    r_pr <= i_priority;
                    r_tk <= i_tick;
                end
            end else begin
                o_status   <= i_status;
                o_thread   <= i_thread;
                o_priority <= i_priority;
                o_last     <= i_last;
                o_tick     <= i_tick;
            end
        end
    end

endmodule

// ----- tb/sleep_wake_timer_queue_checker.sv -----
// ----------------------------------------------------------------------------
// sleep_wake_timer_queue_checker
// watches the item and result channels, predicts every result and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sleep_wake_timer_queue_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               i_action,
    input  logic [7:0]         i_thread_id,
    input  logic signed [31:0] i_sleep_ticks,
    input  logic [5:0]         i_priority_req,
    input  logic               i_valid,
    input  logic [2:0]         i_status,
    input  logic [7:0]         i_woken_thread,
    input  logic [5:0]         i_woken_priority,
    input  logic               i_last,
    input  logic [62:0]        i_tick_now,
    output int                 o_fail_count,
    output int                 o_pending
);
    import swtq_pkg::*;

    typedef struct {
        t_status     status;
        logic [7:0]  thread;
        logic [5:0]  prio;
        logic        last;
        logic [62:0] now;
    } t_wake_result;

    t_wake_result wake_results_q[$];

    logic [TICK_W-1:0] tick_count;
    logic              slot_used  [QUEUE_DEPTH];
    logic [7:0]        slot_thr   [QUEUE_DEPTH];
    logic [TICK_W-1:0] slot_wake  [QUEUE_DEPTH];
    logic [5:0]        slot_prio  [QUEUE_DEPTH];
    int unsigned       slot_age   [QUEUE_DEPTH];

    function automatic bit wakes_earlier(int a, int b);
        if (slot_prio[a] != slot_prio[b]) return slot_prio[a] > slot_prio[b];
        if (slot_wake[a] != slot_wake[b]) return slot_wake[a] < slot_wake[b];
        return slot_age[a] > slot_age[b];
    endfunction

    function automatic void add_result(t_status st, logic [7:0] thr, logic [5:0] pri,
                                       logic lst);
        t_wake_result r;
        r.status = st;
        r.thread = thr;
        r.prio   = pri;
        r.last   = lst;
        r.now    = tick_count[62:0];
        wake_results_q.push_back(r);
    endfunction

    // sleep request: store or refuse; tick: advance and release due entries
    function automatic void predict_wakeups(logic act, logic [7:0] thr,
                                            logic signed [31:0] cnt, logic [5:0] pri);
        int          free_idx;
        int unsigned used;
        int          best;
        int          n;
        logic [TICK_W:0] sum;
        int unsigned rank;
        free_idx = -1;
        used = 0;
        n = 0;
        if (!act) begin
            if (cnt < 1) begin
                add_result(ST_IGNORED, thr, pri, 1'b1);
                return;
            end
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (slot_used[i]) used++;
                else if (free_idx < 0) free_idx = i;
            end
            if (free_idx < 0) begin
                add_result(ST_FULL, thr, pri, 1'b1);
                return;
            end
            sum = {1'b0, tick_count} + {33'd0, cnt};
            slot_used[free_idx] = 1'b1;
            slot_thr[free_idx]  = thr;
            slot_wake[free_idx] = sum[TICK_W] ? '1 : sum[TICK_W-1:0];
            slot_prio[free_idx] = pri;
            slot_age[free_idx]  = used;
            add_result(ST_ACCEPTED, thr, pri, 1'b1);
            return;
        end
        tick_count = tick_count + 1'b1;
        while (n < MAX_BURST) begin
            best = -1;
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (slot_used[i] && slot_wake[i] <= tick_count)
                    if (best < 0 || wakes_earlier(i, best)) best = i;
            end
            if (best < 0) break;
            add_result(ST_WOKEN, slot_thr[best], slot_prio[best], 1'b0);
            rank = slot_age[best];
            slot_used[best] = 1'b0;
            for (int i = 0; i < QUEUE_DEPTH; i++)
                if (slot_used[i] && slot_age[i] > rank) slot_age[i]--;
            n++;
        end
        if (n == 0) add_result(ST_NONE_DUE, 8'd0, 6'd0, 1'b1);
        else wake_results_q[$].last = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_wake_result exp_r;
        if (!i_rst_n) begin
            tick_count = '0;
            for (int i = 0; i < QUEUE_DEPTH; i++) slot_used[i] = 1'b0;
            wake_results_q.delete();
            o_fail_count = 0;
        end else begin
            if (start && !busy)
                predict_wakeups(i_action, i_thread_id, i_sleep_ticks, i_priority_req);
            if (i_valid) begin
                if (wake_results_q.size() == 0) begin
                    $error("result with nothing expected: status %0d", i_status);
                    o_fail_count++;
                end else begin
                    exp_r = wake_results_q.pop_front();
                    if (i_status !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, i_status);
                        o_fail_count++;
                    end
                    if (i_woken_thread !== exp_r.thread) begin
                        $error("woken_thread: expected %0d, got %0d", exp_r.thread,
                               i_woken_thread);
                        o_fail_count++;
                    end
                    if (i_woken_priority !== exp_r.prio) begin
                        $error("woken_priority: expected %0d, got %0d", exp_r.prio,
                               i_woken_priority);
                        o_fail_count++;
                    end
                    if (i_last !== exp_r.last) begin
                        $error("last: expected %0d, got %0d", exp_r.last, i_last);
                        o_fail_count++;
                    end
                    if (i_tick_now !== exp_r.now) begin
                        $error("tick_now: expected %0d, got %0d", exp_r.now, i_tick_now);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = wake_results_q.size();
    end

endmodule

// ----- tb/sleep_wake_timer_queue_tb.sv -----
// ----------------------------------------------------------------------------
// sleep_wake_timer_queue_tb
// drives sleep requests and ticks into the timer queue, gives the verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sleep_wake_timer_queue_tb;
    import swtq_pkg::*;

    localparam int DEPTH    = 16;
    localparam int WD_LIMIT = 2000;   // idle cycles tolerated

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_action = 1'b0;
    logic [7:0]         i_thread_id = '0;
    logic signed [31:0] i_sleep_ticks = '0;
    logic [5:0]         i_priority_req = '0;
    logic               o_valid;
    logic [2:0]         o_status;
    logic [7:0]         o_woken_thread;
    logic [5:0]         o_woken_priority;
    logic               o_last;
    logic [62:0]        o_tick_now;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles = 0;
    bit                 no_gaps = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sleep_wake_timer_queue #(.QUEUE_DEPTH(DEPTH)) i_dut (
        .i_clk, .i_rst_n, .start, .busy, .i_action, .i_thread_id, .i_sleep_ticks,
        .i_priority_req, .o_valid, .o_status, .o_woken_thread, .o_woken_priority,
        .o_last, .o_tick_now
    );

    sleep_wake_timer_queue_checker #(.QUEUE_DEPTH(DEPTH)) i_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_action, .i_thread_id, .i_sleep_ticks,
        .i_priority_req, .i_valid(o_valid), .i_status(o_status),
        .i_woken_thread(o_woken_thread), .i_woken_priority(o_woken_priority),
        .i_last(o_last), .i_tick_now(o_tick_now), .o_fail_count(fail_count),
        .o_pending(pending)
    );

    // watchdog: cycles with no item taken and no result seen
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // present one item and hold it until the block takes it; start stays high
    task automatic send_item(logic act, logic [7:0] thr, logic signed [31:0] cnt,
                             logic [5:0] pri);
        if (!no_gaps && $urandom_range(99) < 6) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_action       <= act;
        i_thread_id    <= thr;
        i_sleep_ticks  <= cnt;
        i_priority_req <= pri;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic send_tick();
        send_item(1'b1, 8'($urandom), 32'($urandom), 6'($urandom));
    endtask

    initial begin
        int roll;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty tick, ignored counts, field extremes
        send_tick();
        send_item(1'b0, 8'd0, 32'sd0, 6'd0);
        send_item(1'b0, 8'd255, 32'sh8000_0000, 6'd63);
        send_item(1'b0, 8'd1, 32'sh7fff_ffff, 6'd63);    // never wakes in this run
        // ordering: priority, then wake time, then later request first
        send_item(1'b0, 8'd10, 32'sd2, 6'd5);
        send_item(1'b0, 8'd11, 32'sd2, 6'd5);
        send_item(1'b0, 8'd12, 32'sd2, 6'd40);
        send_item(1'b0, 8'd13, 32'sd1, 6'd5);
        send_tick();
        send_tick();
        // fill every slot, one more is refused, then a long burst on one tick
        for (int k = 0; k < DEPTH; k++)
            send_item(1'b0, 8'($urandom), 32'sd3, 6'($urandom_range(3)));
        repeat (3) send_tick();

        // hold off until the queue has drained its results
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        // random: mostly short sleeps and ticks, some noise
        for (int k = 0; k < 100; k++) begin
            no_gaps = (k >= 40 && k < 70);
            roll = $urandom_range(99);
            if (roll < 45)
                send_tick();
            else if (roll < 85)
                send_item(1'b0, 8'($urandom), 32'($urandom_range(12, 1)), 6'($urandom));
            else if (roll < 97)
                send_item(1'b0, 8'($urandom), 32'($urandom) | 32'h8000_0000, 6'($urandom));
            else
                send_item(1'b0, 8'($urandom), 32'($urandom) & 32'h7fff_ffff, 6'($urandom));
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
